// ===== sv/kvrs_pkg.sv =====
// shared types and codes for the layered key/value row store
`default_nettype none

package kvrs_pkg;

  // request action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_COUNT  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_APPEND = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  // command field widths, sized for the largest supported configuration
  localparam int CMD_ROW_W  = 10;
  localparam int CMD_ADDR_W = 16;
  localparam int CMD_LEN_W  = 7;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  layer;
    logic [6:0]  token;
    logic [7:0]  end_token;
    logic [2:0]  element;
    logic [31:0] key_word;
    logic [31:0] value_word;
  } kv_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [2:0]  token_offset;
    logic [2:0]  element_index;
    logic [8:0]  used_rows;
    logic        last;
  } kv_out_t;

  // classified work handed from front to back
  typedef enum logic [2:0] {
    CMD_APPEND,
    CMD_GET,
    CMD_COUNT,
    CMD_CLEAR,
    CMD_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [2:0]            status;
    logic [CMD_ROW_W-1:0]  row;
    logic [CMD_ADDR_W-1:0] addr;
    logic [CMD_LEN_W-1:0]  len;
    logic                  last_elem;
    logic [31:0]           key_word;
    logic [31:0]           value_word;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/kvrs_ram.sv =====
// generic single-write, single-read RAM with registered read data
`default_nettype none

module kvrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/kvrs_front.sv =====
// request decode, range checks and two-entry command queue
`default_nettype none

module kvrs_front #(
  parameter int LAYERS         = 4,
  parameter int CAPACITY       = 64,
  parameter int ROW_WORDS      = 8,
  parameter int MAX_GET_TOKENS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire kvrs_pkg::kv_in_t in_data,
  output logic                 cmd_valid,
  output kvrs_pkg::cmd_t       cmd,
  input  wire logic            cmd_pop
);

  import kvrs_pkg::*;

  localparam logic [31:0] LAYERS_C   = 32'(LAYERS);
  localparam logic [31:0] CAP_C      = 32'(CAPACITY);
  localparam logic [31:0] WORDS_C    = 32'(ROW_WORDS);
  localparam logic [31:0] MAX_TOK_C  = 32'(MAX_GET_TOKENS);

  logic [31:0] row_full;
  logic [31:0] base_full;
  logic [7:0]  len;
  logic        layer_bad;
  cmd_t        dec;

  logic        push;
  cmd_t        q_r [2];
  logic        wr_r;
  logic        rd_r;
  logic [1:0]  cnt_r;

  // row and word address of the request
  always_comb begin
    row_full  = 32'(in_data.layer) * CAP_C + 32'(in_data.token);
    base_full = row_full * WORDS_C;
    len       = in_data.end_token - {1'b0, in_data.token};
    layer_bad = 32'(in_data.layer) >= LAYERS_C;
  end

  // classify the request
  always_comb begin
    dec            = '0;
    dec.kind       = CMD_STATUS;
    dec.status     = ST_OK;
    dec.row        = row_full[CMD_ROW_W-1:0];
    dec.addr       = base_full[CMD_ADDR_W-1:0];
    dec.len        = len[CMD_LEN_W-1:0];
    dec.last_elem  = 32'(in_data.element) == WORDS_C - 32'd1;
    dec.key_word   = in_data.key_word;
    dec.value_word = in_data.value_word;
    case (in_data.action)
      ACT_APPEND: begin
        if (layer_bad || 32'(in_data.token) >= CAP_C ||
            32'(in_data.element) >= WORDS_C) begin
          dec.status = ST_BAD_APPEND;
        end else begin
          dec.kind = CMD_APPEND;
          dec.addr = CMD_ADDR_W'(base_full + 32'(in_data.element));
        end
      end
      ACT_GET: begin
        if (layer_bad || {1'b0, in_data.token} > in_data.end_token ||
            32'(in_data.end_token) > CAP_C) begin
          dec.status = ST_BAD_RANGE;
        end else if (32'(len) > MAX_TOK_C) begin
          dec.status = ST_TOO_LONG;
        end else if (len == 8'd0) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.kind = CMD_GET;
        end
      end
      ACT_COUNT: dec.kind = CMD_COUNT;
      ACT_CLEAR: dec.kind = CMD_CLEAR;
      default:   dec.kind = CMD_STATUS;
    endcase
  end

  // command queue
  assign in_stall  = cnt_r == 2'd2;
  assign push      = in_valid && !in_stall;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (cmd_pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/kvrs_back.sv =====
// command execution: row storage, valid bits, get sequencing, result buffer
`default_nettype none

module kvrs_back #(
  parameter int LAYERS         = 4,
  parameter int CAPACITY       = 64,
  parameter int ROW_WORDS      = 8,
  parameter int MAX_GET_TOKENS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire kvrs_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output kvrs_pkg::kv_out_t   out_data
);

  import kvrs_pkg::*;

  localparam int ROW_COUNT  = LAYERS * CAPACITY;
  localparam int WORD_COUNT = ROW_COUNT * ROW_WORDS;
  localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int EW         = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int LW         = $clog2(MAX_GET_TOKENS + 1);
  localparam int CW         = $clog2(ROW_COUNT + 1);

  // get sequencing
  logic             busy_r;
  logic [EW-1:0]    elem_r;
  logic [LW-1:0]    tok_r;
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]    addr_r;

  logic [EW-1:0]    eff_elem;
  logic [LW-1:0]    eff_tok;
  logic [ROW_W-1:0] eff_row;
  logic [AW-1:0]    eff_addr;
  logic             elem_end;
  logic             tok_end;
  logic             final_res;
  logic             is_get;
  logic             is_append;

  // row state
  logic [ROW_COUNT-1:0] row_valid_r;
  logic [CW-1:0]        count_r;

  // read stage and result buffer
  logic    p1_r;
  logic    p1_rd_r;
  logic    p1_zero_r;
  kv_out_t p1_data_r;
  kv_out_t p1_res;
  kv_out_t res;

  kv_out_t     om_r [2];
  logic        owr_r;
  logic        ord_r;
  logic [1:0]  ocnt_r;
  logic        opop;
  logic        issue;
  logic [31:0] key_q;
  logic [31:0] value_q;

  // position within the current command
  always_comb begin
    eff_elem  = busy_r ? elem_r : '0;
    eff_tok   = busy_r ? tok_r : '0;
    eff_row   = busy_r ? row_r : cmd.row[ROW_W-1:0];
    eff_addr  = busy_r ? addr_r : cmd.addr[AW-1:0];
    elem_end  = eff_elem == EW'(ROW_WORDS - 1);
    tok_end   = eff_tok == cmd.len[LW-1:0] - LW'(1);
    is_get    = cmd.kind == CMD_GET;
    is_append = cmd.kind == CMD_APPEND;
    final_res = !is_get || (elem_end && tok_end);
  end

  // issue one result when the buffer can take it, counting the read in flight
  assign opop    = out_valid && !out_stall;
  assign issue   = cmd_valid && ((3'(ocnt_r) + 3'(p1_r) <= 3'd1) || opop);
  assign cmd_pop = issue && final_res;

  // result fields known at issue
  always_comb begin
    res               = '0;
    res.status        = cmd.status;
    res.last          = final_res;
    case (cmd.kind)
      CMD_GET: begin
        res.token_offset  = 3'(eff_tok);
        res.element_index = 3'(eff_elem);
      end
      CMD_COUNT: res.used_rows = 9'(count_r);
      default:   res.used_rows = 9'd0;
    endcase
  end

  // get counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (issue && is_get) begin
      busy_r <= !final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && is_get) begin
      addr_r <= eff_addr + AW'(1);
      if (elem_end) begin
        elem_r <= '0;
        tok_r  <= eff_tok + LW'(1);
        row_r  <= eff_row + ROW_W'(1);
      end else begin
        elem_r <= eff_elem + EW'(1);
        tok_r  <= eff_tok;
        row_r  <= eff_row;
      end
    end
  end

  // valid bits and valid row count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      count_r     <= '0;
    end else if (issue) begin
      if (cmd.kind == CMD_CLEAR) begin
        row_valid_r <= '0;
        count_r     <= '0;
      end else if (is_append && cmd.last_elem && !row_valid_r[eff_row]) begin
        row_valid_r[eff_row] <= 1'b1;
        count_r              <= count_r + CW'(1);
      end
    end
  end

  // key and value word stores
  kvrs_ram #(
    .WIDTH(32),
    .DEPTH(WORD_COUNT)
  ) u_key_ram (
    .clk  (clk),
    .we   (issue && is_append),
    .waddr(eff_addr),
    .wdata(cmd.key_word),
    .re   (issue && is_get),
    .raddr(eff_addr),
    .rdata(key_q)
  );

  kvrs_ram #(
    .WIDTH(32),
    .DEPTH(WORD_COUNT)
  ) u_value_ram (
    .clk  (clk),
    .we   (issue && is_append),
    .waddr(eff_addr),
    .wdata(cmd.value_word),
    .re   (issue && is_get),
    .raddr(eff_addr),
    .rdata(value_q)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
    end else begin
      p1_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_data_r <= res;
      p1_rd_r   <= is_get;
      p1_zero_r <= !row_valid_r[eff_row];
    end
  end

  // merge read data into the staged result
  always_comb begin
    p1_res = p1_data_r;
    if (p1_rd_r && !p1_zero_r) begin
      p1_res.key_out   = key_q;
      p1_res.value_out = value_q;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (p1_r) begin
      om_r[owr_r] <= p1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (p1_r) begin
        owr_r <= !owr_r;
      end
      if (opop) begin
        ord_r <= !ord_r;
      end
      ocnt_r <= ocnt_r + 2'(p1_r) - 2'(opop);
    end
  end

  assign out_valid = ocnt_r != 2'd0;
  assign out_data  = om_r[ord_r];

endmodule

`default_nettype wire

// ===== sv/layered_kv_row_store_top.sv =====
// top level of the layered key/value row store
`default_nettype none

// Key/value row store: one key row and one value row of HEADS*HEAD_SIZE words
// per (layer, token slot), with a valid bit per row. Append, count and clear
// requests produce one result each and go through at one request per cycle
// while the output is not stalled. A get over [token, end_token) produces one
// result per stored word, one per cycle while the output is not stalled, and
// holds the back end until its last word is read through the single read port
// of the word stores. A two-entry command queue lets new requests be taken
// while a get streams out, and a two-entry result buffer holds results while
// the consumer stalls. When nothing is waiting, a result passes through the
// command queue, the read stage and the result buffer before it is offered.
// Row valid bits clear at reset; stored words are undefined until appended.
module layered_kv_row_store_top #(
  parameter int LAYERS         = 4,
  parameter int CAPACITY       = 64,
  parameter int HEADS          = 2,
  parameter int HEAD_SIZE      = 4,
  parameter int MAX_GET_TOKENS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire kvrs_pkg::kv_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kvrs_pkg::kv_out_t     out_data
);

  import kvrs_pkg::*;

  localparam int ROW_WORDS = HEADS * HEAD_SIZE;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // request decode and queue
  kvrs_front #(
    .LAYERS        (LAYERS),
    .CAPACITY      (CAPACITY),
    .ROW_WORDS     (ROW_WORDS),
    .MAX_GET_TOKENS(MAX_GET_TOKENS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // storage and result generation
  kvrs_back #(
    .LAYERS        (LAYERS),
    .CAPACITY      (CAPACITY),
    .ROW_WORDS     (ROW_WORDS),
    .MAX_GET_TOKENS(MAX_GET_TOKENS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
